// File: hdl/tpg_pkg.sv
// Shared phase codes and register indexes for the trapezoid pulse generator.
`default_nettype none
package tpg_pkg;

   typedef enum logic [2:0] {
      PH_INITIAL = 3'd0,
      PH_RISING  = 3'd1,
      PH_HIGH    = 3'd2,
      PH_FALLING = 3'd3,
      PH_PAST    = 3'd4
   } phase_type;

   localparam logic [2:0] REG_INITIAL_VALUE = 3'd0;
   localparam logic [2:0] REG_PULSE_VALUE   = 3'd1;
   localparam logic [2:0] REG_DELAY_TICKS   = 3'd2;
   localparam logic [2:0] REG_RISE_TICKS    = 3'd3;
   localparam logic [2:0] REG_FALL_TICKS    = 3'd4;
   localparam logic [2:0] REG_WIDTH_TICKS   = 3'd5;
   localparam logic [2:0] REG_PERIOD_TICKS  = 3'd6;

endpackage
`default_nettype wire

// File: hdl/tpg_front.sv
// Front end: accepts time stamps and folds them into one period with a pipelined divider.
`default_nettype none
module tpg_front
   import tpg_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [TIME_BITS-1:0] in_time,
   input  wire logic [TIME_BITS-1:0] delay_ticks,
   input  wire logic [TIME_BITS-1:0] period_ticks,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [TIME_BITS-1:0]      out_raw,
   output logic [TIME_BITS-1:0]      out_time
);

   localparam int N = TIME_BITS;

   logic [N:0]   v_ff;
   logic [N:0]   fold_ff;
   logic [N-1:0] raw_ff [N+1];
   logic [N-1:0] x_ff   [N+1];
   logic [N-1:0] r_ff   [N+1];
   logic [N-1:0] r_in   [N];
   logic         en;

   assign en       = !v_ff[N] || out_ready;
   assign in_ready = en;

   // Stage k+1 brings in bit N-1-k of the offset past the delay.
   for (genvar k = 0; k < N; k++) begin : g_step
      logic [N:0] r2;
      always_comb begin
         r2 = {r_ff[k], x_ff[k][N-1-k]};
         if (r2 >= {1'b0, period_ticks}) begin
            r2 = r2 - {1'b0, period_ticks};
         end
         r_in[k] = r2[N-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[N-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         raw_ff[0]  <= in_time;
         x_ff[0]    <= in_time - delay_ticks;
         r_ff[0]    <= '0;
         fold_ff[0] <= (period_ticks != '0) && (in_time > delay_ticks);
         for (int k = 0; k < N; k++) begin
            raw_ff[k+1]  <= raw_ff[k];
            x_ff[k+1]    <= x_ff[k];
            r_ff[k+1]    <= r_in[k];
            fold_ff[k+1] <= fold_ff[k];
         end
      end
   end

   assign out_valid = v_ff[N];
   assign out_raw   = raw_ff[N];
   assign out_time  = fold_ff[N] ? r_ff[N] + delay_ticks : raw_ff[N];

endmodule
`default_nettype wire

// File: hdl/tpg_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none
module tpg_queue
   import tpg_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output logic [WIDTH-1:0]      pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: hdl/tpg_back.sv
// Back end: phase decision, next corner, and ramp interpolation through a pipelined divider.
`default_nettype none
module tpg_back
   import tpg_pkg::*;
#(
   parameter int TIME_BITS  = 32,
   parameter int VALUE_BITS = 24
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic signed [VALUE_BITS-1:0] initial_value,
   input  wire logic signed [VALUE_BITS-1:0] pulse_value,
   input  wire logic [TIME_BITS-1:0]         delay_ticks,
   input  wire logic [TIME_BITS-1:0]         rise_ticks,
   input  wire logic [TIME_BITS-1:0]         fall_ticks,
   input  wire logic [TIME_BITS-1:0]         width_ticks,
   input  wire logic [TIME_BITS-1:0]         period_ticks,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [TIME_BITS-1:0]         in_raw,
   input  wire logic [TIME_BITS-1:0]         in_time,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic signed [VALUE_BITS-1:0]      out_level,
   output phase_type                         out_phase,
   output logic [TIME_BITS-1:0]              out_next
);

   localparam int TB = TIME_BITS;
   localparam int VB = VALUE_BITS;
   localparam int QB = VB + 1;
   localparam int PB = TB + QB;
   localparam int SB = TB + 3;

   logic en;
   assign en       = !out_valid || out_ready;
   assign in_ready = en;

   // Decision stage
   logic [SB-1:0]        dl_x, cr, cf, ce, tt, off_x, sum_n;
   logic [TB-1:0]        off;
   logic                 endless;
   phase_type            ph_c;
   logic signed [VB-1:0] from_c, to_c;
   logic [SB-1:0]        num_c;
   logic [TB-1:0]        den_c;
   logic                 ramp_c;
   logic [TB-1:0]        nxt_c;
   logic signed [VB:0]   diff;
   logic [VB:0]          mag_c;

   function automatic logic [TIME_BITS-1:0] sat(input logic [TIME_BITS+2:0] x);
      if (x[TIME_BITS+2:TIME_BITS] != 3'd0) begin
         return '1;
      end
      return x[TIME_BITS-1:0];
   endfunction

   always_comb begin
      dl_x    = SB'(delay_ticks);
      cr      = dl_x + SB'(rise_ticks);
      cf      = cr + SB'(width_ticks);
      ce      = cf + SB'(fall_ticks);
      tt      = SB'(in_time);
      off     = in_raw - in_time;
      off_x   = SB'(off);
      endless = width_ticks == '0;
      from_c  = initial_value;
      to_c    = initial_value;
      num_c   = '0;
      // Outside the ramps the product is zero and the divisor all ones, so the quotient stays zero.
      den_c   = '1;
      ramp_c  = 1'b0;
      sum_n   = '0;
      priority if (!endless && tt >= ce) begin
         ph_c  = PH_PAST;
         sum_n = dl_x + SB'(period_ticks) + off_x;
         nxt_c = (period_ticks == '0) ? '1 : sat(sum_n);
      end else if (!endless && tt >= cf) begin
         ph_c   = PH_FALLING;
         from_c = pulse_value;
         to_c   = initial_value;
         num_c  = tt - cf;
         den_c  = fall_ticks;
         ramp_c = 1'b1;
         sum_n  = ce + off_x;
         nxt_c  = sat(sum_n);
      end else if (tt >= cr) begin
         ph_c   = PH_HIGH;
         from_c = pulse_value;
         sum_n  = cf + off_x;
         nxt_c  = endless ? '1 : sat(sum_n);
      end else if (tt >= dl_x) begin
         ph_c   = PH_RISING;
         from_c = initial_value;
         to_c   = pulse_value;
         num_c  = tt - dl_x;
         den_c  = rise_ticks;
         ramp_c = 1'b1;
         sum_n  = cr + off_x;
         nxt_c  = sat(sum_n);
      end else begin
         ph_c  = PH_INITIAL;
         sum_n = dl_x + off_x;
         nxt_c = sat(sum_n);
      end
      diff  = (VB + 1)'(to_c) - (VB + 1)'(from_c);
      mag_c = ramp_c ? (diff[VB] ? (VB + 1)'(-diff) : diff) : '0;
   end

   // Stage A: decision registered
   logic                 a_v_ff;
   phase_type            a_ph_ff;
   logic signed [VB-1:0] a_from_ff;
   logic                 a_neg_ff;
   logic [VB:0]          a_mag_ff;
   logic [TB-1:0]        a_num_ff, a_den_ff, a_nxt_ff;

   // Stage B: product registered
   logic                 b_v_ff;
   phase_type            b_ph_ff;
   logic signed [VB-1:0] b_from_ff;
   logic                 b_neg_ff;
   logic [PB-1:0]        b_prod_ff;
   logic [TB-1:0]        b_den_ff, b_nxt_ff;

   // Division stages
   logic [QB:0]          d_v_ff;
   phase_type            d_ph_ff   [QB+1];
   logic signed [VB-1:0] d_from_ff [QB+1];
   logic [QB:0]          d_neg_ff;
   logic [TB-1:0]        d_rem_ff  [QB+1];
   logic [QB-1:0]        d_low_ff  [QB+1];
   logic [QB-1:0]        d_q_ff    [QB+1];
   logic [TB-1:0]        d_den_ff  [QB+1];
   logic [TB-1:0]        d_nxt_ff  [QB+1];
   logic [TB-1:0]        rem_in    [QB];
   logic [QB-1:0]        qbit_in;

   for (genvar j = 0; j < QB; j++) begin : g_div
      logic [TB:0] r2;
      always_comb begin
         r2 = {d_rem_ff[j], d_low_ff[j][QB-1-j]};
         qbit_in[j] = r2 >= {1'b0, d_den_ff[j]};
         if (qbit_in[j]) begin
            r2 = r2 - {1'b0, d_den_ff[j]};
         end
         rem_in[j] = r2[TB-1:0];
      end
   end

   // Output register
   logic [VB:0] lev_x;
   logic        o_v_ff;
   logic signed [VB-1:0] o_level_ff;
   phase_type   o_ph_ff;
   logic [TB-1:0] o_nxt_ff;

   always_comb begin
      if (d_neg_ff[QB]) begin
         lev_x = (VB + 1)'(d_from_ff[QB]) - d_q_ff[QB];
      end else begin
         lev_x = (VB + 1)'(d_from_ff[QB]) + d_q_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         d_v_ff <= '0;
         o_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= in_valid;
         b_v_ff <= a_v_ff;
         d_v_ff <= {d_v_ff[QB-1:0], b_v_ff};
         o_v_ff <= d_v_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ph_ff   <= ph_c;
         a_from_ff <= from_c;
         a_neg_ff  <= diff[VB];
         a_mag_ff  <= mag_c;
         a_num_ff  <= num_c[TB-1:0];
         a_den_ff  <= den_c;
         a_nxt_ff  <= nxt_c;

         b_ph_ff   <= a_ph_ff;
         b_from_ff <= a_from_ff;
         b_neg_ff  <= a_neg_ff;
         b_prod_ff <= PB'(a_num_ff) * PB'(a_mag_ff);
         b_den_ff  <= a_den_ff;
         b_nxt_ff  <= a_nxt_ff;

         // The quotient is known to fit in QB bits, so the top bits start below the divisor.
         d_ph_ff[0]   <= b_ph_ff;
         d_from_ff[0] <= b_from_ff;
         d_neg_ff[0]  <= b_neg_ff;
         d_rem_ff[0]  <= b_prod_ff[PB-1:QB];
         d_low_ff[0]  <= b_prod_ff[QB-1:0];
         d_q_ff[0]    <= '0;
         d_den_ff[0]  <= b_den_ff;
         d_nxt_ff[0]  <= b_nxt_ff;
         for (int j = 0; j < QB; j++) begin
            d_ph_ff[j+1]   <= d_ph_ff[j];
            d_from_ff[j+1] <= d_from_ff[j];
            d_neg_ff[j+1]  <= d_neg_ff[j];
            d_rem_ff[j+1]  <= rem_in[j];
            d_low_ff[j+1]  <= d_low_ff[j];
            d_q_ff[j+1]    <= {d_q_ff[j][QB-2:0], qbit_in[j]};
            d_den_ff[j+1]  <= d_den_ff[j];
            d_nxt_ff[j+1]  <= d_nxt_ff[j];
         end

         o_level_ff <= lev_x[VB-1:0];
         o_ph_ff    <= d_ph_ff[QB];
         o_nxt_ff   <= d_nxt_ff[QB];
      end
   end

   assign out_valid = o_v_ff;
   assign out_level = o_level_ff;
   assign out_phase = o_ph_ff;
   assign out_next  = o_nxt_ff;

endmodule
`default_nettype wire

// File: hdl/trapezoid_pulse_generator.sv
// Periodic trapezoidal pulse generator: top level with configuration registers.
//
// Usage: each item on the req_ channel is a time stamp in ticks; for every item one
// result comes out on the rsp_ channel with the waveform level, the phase (initial,
// rising, high, falling, past) and the absolute time of the next corner (all ones
// when there is none). Results leave in the order the time stamps came in.
// The csr_ port writes the seven registers (levels, delay, rise, fall, width,
// period); write them only while no item is in flight.
// Throughput is one item per clock while the receiver keeps rsp_tready high. The front end
// folds the time into one period with one remainder bit per stage; each item then
// passes through the queue and the back end (decision, product, division and output
// registers), where the ramp quotient is found one bit per stage.
// Synchronous reset clears the configuration registers to zero and empties the pipelines and the queue.
// When the receiver holds rsp_tready low, the back end halts, the two-entry queue
// fills, and then req_tready drops; no item is lost or repeated.
`default_nettype none
module trapezoid_pulse_generator
   import tpg_pkg::*;
#(
   parameter int TIME_BITS  = 32,
   parameter int VALUE_BITS = 24
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // time_now
   input  wire logic [((TIME_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // level, phase, next_corner
   output logic [((VALUE_BITS+3+TIME_BITS+7)/8)*8-1:0] rsp_tdata,
   input  wire logic csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [((TIME_BITS > VALUE_BITS) ? TIME_BITS : VALUE_BITS)-1:0] csr_wdata
);

   localparam int TB   = TIME_BITS;
   localparam int VB   = VALUE_BITS;
   localparam int OUTW = ((VB + 3 + TB + 7) / 8) * 8;

   logic signed [VB-1:0] iv_ff, pv_ff;
   logic [TB-1:0]        dl_ff, rs_ff, fl_ff, wd_ff, pd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff <= '0;
         pv_ff <= '0;
         dl_ff <= '0;
         rs_ff <= '0;
         fl_ff <= '0;
         wd_ff <= '0;
         pd_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_INITIAL_VALUE: iv_ff <= csr_wdata[VB-1:0];
            REG_PULSE_VALUE:   pv_ff <= csr_wdata[VB-1:0];
            REG_DELAY_TICKS:   dl_ff <= csr_wdata[TB-1:0];
            REG_RISE_TICKS:    rs_ff <= csr_wdata[TB-1:0];
            REG_FALL_TICKS:    fl_ff <= csr_wdata[TB-1:0];
            REG_WIDTH_TICKS:   wd_ff <= csr_wdata[TB-1:0];
            REG_PERIOD_TICKS:  pd_ff <= csr_wdata[TB-1:0];
            default: ;
         endcase
      end
   end

   logic          f_valid, q_full, q_ne, b_ready;
   logic [TB-1:0] f_raw, f_time;
   logic [2*TB-1:0] q_data;

   tpg_front #(.TIME_BITS(TB)) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_time      (req_tdata[TB-1:0]),
      .delay_ticks  (dl_ff),
      .period_ticks (pd_ff),
      .out_valid    (f_valid),
      .out_ready    (!q_full),
      .out_raw      (f_raw),
      .out_time     (f_time)
   );

   tpg_queue #(.WIDTH(2 * TB)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data ({f_raw, f_time}),
      .full      (q_full),
      .pop       (b_ready),
      .not_empty (q_ne),
      .pop_data  (q_data)
   );

   logic signed [VB-1:0] level;
   phase_type            phase;
   logic [TB-1:0]        next_corner;

   tpg_back #(.TIME_BITS(TB), .VALUE_BITS(VB)) u_back (
      .clock         (clock),
      .reset         (reset),
      .initial_value (iv_ff),
      .pulse_value   (pv_ff),
      .delay_ticks   (dl_ff),
      .rise_ticks    (rs_ff),
      .fall_ticks    (fl_ff),
      .width_ticks   (wd_ff),
      .period_ticks  (pd_ff),
      .in_valid      (q_ne),
      .in_ready      (b_ready),
      .in_raw        (q_data[2*TB-1:TB]),
      .in_time       (q_data[TB-1:0]),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_level     (level),
      .out_phase     (phase),
      .out_next      (next_corner)
   );

   assign rsp_tdata = OUTW'({next_corner, phase, level});

endmodule
`default_nettype wire
